FILE: hw/rtl/dnsexp_pkg.sv
// ============================================================================
// dnsexp_pkg
// Shared types and codes for the DNS server expiry table.
// ============================================================================
package dnsexp_pkg;

   localparam logic [1:0] CMD_CLEAR = 2'd0;
   localparam logic [1:0] CMD_ADD   = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_REJECTED = 2'd1;
   localparam logic [1:0] ST_OVERFLOW = 2'd2;

   localparam logic [9:0] MS_PER_S = 10'd1000;

   localparam int ENTRY_W = 192;

   typedef struct packed {
      logic [63:0] addr_hi;
      logic [63:0] addr_lo;
      logic [63:0] expiry;
   } entry_type;

endpackage

FILE: hw/rtl/dnsexp_ram.sv
// ============================================================================
// dnsexp_ram
// Generic single write port, single read port RAM with registered read.
// ============================================================================
module dnsexp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

FILE: hw/rtl/dns_server_expiry_table_unit.sv
// Clear and unknown commands answer straight from idle; add walks the stored
// entries for a matching address; batch end runs an insertion sort, latest
// expiry first, then a trim and mark walk.
// Read walks the table entry by entry, waiting while a response is held.
// One item is worked at a time; the table lives in one RAM, one port each way.
// Reset (synchronous, active high) empties the table and clears all flags.
// ============================================================================
// dns_server_expiry_table_unit
// Table of DNS server addresses with expiry, sort, trim and current marking.
// ============================================================================
module dns_server_expiry_table_unit #(
   parameter int TABLE_DEPTH = 16,
   parameter int MAX_KEPT    = 12,
   parameter int MAX_CURRENT = 3
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_command,
   input  logic [63:0] req_address_hi,
   input  logic [63:0] req_address_lo,
   input  logic [31:0] req_lifetime_s,
   input  logic [63:0] req_now_ms,
   input  logic        req_last_in_batch,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic        rsp_changed,
   output logic        rsp_server_valid,
   output logic [63:0] rsp_server_hi,
   output logic [63:0] rsp_server_lo,
   output logic        rsp_last_result
);
   import dnsexp_pkg::*;

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int KW = $clog2(MAX_CURRENT + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
   localparam logic [CW-1:0] KEPT_C  = (MAX_KEPT > TABLE_DEPTH) ? CW'(TABLE_DEPTH)
                                                               : CW'(MAX_KEPT);
   localparam logic [KW-1:0] MAXC_C  = KW'(MAX_CURRENT);

   typedef enum logic [11:0] {
      S_IDLE   = 12'b000000000001,
      S_MRD    = 12'b000000000010,
      S_MCHK   = 12'b000000000100,
      S_CLOSE  = 12'b000000001000,
      S_SRDI   = 12'b000000010000,
      S_SRDJ   = 12'b000000100000,
      S_SCMP   = 12'b000001000000,
      S_TRD    = 12'b000010000000,
      S_TCHK   = 12'b000100000000,
      S_MARK   = 12'b001000000000,
      S_RRD    = 12'b010000000000,
      S_RCHK   = 12'b100000000000
   } state_type;

   state_type state_ff, state_in;

   logic [31:0]          min_life_ff;
   logic [CW-1:0]        count_ff, count_in;
   logic                 rej_ff, rej_in, ovf_ff, ovf_in;
   logic [TABLE_DEPTH-1:0] cur_ff, cur_in;
   logic [1:0]           cmd_ff;
   logic [63:0]          ahi_ff, alo_ff, now_ff, exp_ff;
   logic [63:0]          ahi_in, alo_in, now_in, exp_in;
   logic                 last_ff, last_in;
   logic [1:0]           cmd_in;
   logic [CW-1:0]        i_ff, i_in, j_ff, j_in;
   logic [KW-1:0]        k_ff, k_in;
   logic                 chg_ff, chg_in;
   entry_type            key_ff, key_in;
   logic                 keyc_ff, keyc_in;

   logic                 ov_ff, ov_in;
   logic [1:0]           ost_ff, ost_in;
   logic                 och_ff, och_in, osv_ff, osv_in, olast_ff, olast_in;
   logic [63:0]          ohi_ff, ohi_in, olo_ff, olo_in;

   logic                 wr_en;
   logic [AW-1:0]        wr_addr, rd_addr;
   entry_type            wr_data, rd_data;
   logic [ENTRY_W-1:0]   rd_raw;

   dnsexp_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );
   assign rd_data = entry_type'(rd_raw);

   logic [41:0] life_ms;
   logic [63:0] new_exp;
   logic [KW:0] cur_cnt;
   assign life_ms = 42'(req_lifetime_s) * 42'(MS_PER_S);
   assign new_exp = req_now_ms + 64'(life_ms);

   always_comb begin
      cur_cnt = '0;
      for (int n = 0; n < TABLE_DEPTH; n++) begin
         if (cur_ff[n] && (CW'(n) < count_ff) && cur_cnt <= (KW+1)'(MAX_CURRENT)) begin
            cur_cnt = cur_cnt + 1'b1;
         end
      end
   end

   assign req_ready = (state_ff == S_IDLE) && !ov_ff;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      rej_in   = rej_ff;
      ovf_in   = ovf_ff;
      cur_in   = cur_ff;
      cmd_in   = cmd_ff;
      ahi_in   = ahi_ff;
      alo_in   = alo_ff;
      now_in   = now_ff;
      exp_in   = exp_ff;
      last_in  = last_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      k_in     = k_ff;
      chg_in   = chg_ff;
      key_in   = key_ff;
      keyc_in  = keyc_ff;
      ov_in    = ov_ff && !rsp_ready;
      ost_in   = ost_ff;
      och_in   = och_ff;
      osv_in   = osv_ff;
      olast_in = olast_ff;
      ohi_in   = ohi_ff;
      olo_in   = olo_ff;
      wr_en    = 1'b0;
      wr_addr  = '0;
      wr_data  = '0;
      rd_addr  = AW'(i_ff);

      case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               cmd_in  = req_command;
               ahi_in  = req_address_hi;
               alo_in  = req_address_lo;
               now_in  = req_now_ms;
               exp_in  = new_exp;
               last_in = req_last_in_batch;
               i_in    = '0;
               k_in    = '0;
               chg_in  = 1'b0;
               case (req_command)
                  CMD_CLEAR: begin
                     ov_in = 1'b1; ost_in = ST_OK; osv_in = 1'b0; olast_in = 1'b1;
                     ohi_in = '0; olo_in = '0;
                     och_in = (cur_cnt != '0);
                     cur_in = '0; count_in = '0; rej_in = 1'b0; ovf_in = 1'b0;
                  end
                  CMD_ADD: begin
                     if (req_lifetime_s != '0 && req_lifetime_s < min_life_ff) begin
                        rej_in   = 1'b1;
                        state_in = S_CLOSE;
                     end else begin
                        state_in = S_MRD;
                     end
                  end
                  CMD_READ: begin
                     state_in = S_RRD;
                  end
                  default: begin
                     ov_in = 1'b1; ost_in = ST_OK; och_in = 1'b0; osv_in = 1'b0;
                     olast_in = 1'b1; ohi_in = '0; olo_in = '0;
                  end
               endcase
            end
         end
         S_MRD: begin
            if (i_ff < count_ff) begin
               state_in = S_MCHK;
            end else begin
               if (exp_ff > now_ff) begin
                  if (count_ff < DEPTH_C) begin
                     wr_en   = 1'b1;
                     wr_addr = AW'(count_ff);
                     wr_data = '{addr_hi: ahi_ff, addr_lo: alo_ff, expiry: exp_ff};
                     cur_in[AW'(count_ff)] = 1'b0;
                     count_in = count_ff + 1'b1;
                  end else begin
                     ovf_in = 1'b1;
                  end
               end
               state_in = S_CLOSE;
            end
         end
         S_MCHK: begin
            if (rd_data.addr_hi == ahi_ff && rd_data.addr_lo == alo_ff) begin
               wr_en    = 1'b1;
               wr_addr  = AW'(i_ff);
               wr_data  = '{addr_hi: ahi_ff, addr_lo: alo_ff, expiry: exp_ff};
               state_in = S_CLOSE;
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = S_MRD;
            end
         end
         S_CLOSE: begin
            if (!last_ff) begin
               state_in = S_IDLE;
            end else if (rej_ff) begin
               ov_in = 1'b1; ost_in = ST_REJECTED; och_in = 1'b0; osv_in = 1'b0;
               olast_in = 1'b1; ohi_in = '0; olo_in = '0;
               rej_in = 1'b0; ovf_in = 1'b0;
               state_in = S_IDLE;
            end else begin
               i_in     = CW'(1);
               state_in = S_SRDI;
            end
         end
         S_SRDI: begin
            // load key entry i
            if (i_ff >= count_ff) begin
               i_in     = count_ff;
               state_in = S_TRD;
            end else begin
               state_in = S_SRDJ;
               j_in     = i_ff;
            end
         end
         S_SRDJ: begin
            key_in   = rd_data;
            keyc_in  = cur_ff[AW'(i_ff)];
            rd_addr  = AW'(j_ff - 1'b1);
            state_in = S_SCMP;
         end
         S_SCMP: begin
            rd_addr = AW'(j_ff - 1'b1);
            if (rd_data.expiry < key_ff.expiry) begin
               wr_en   = 1'b1;
               wr_addr = AW'(j_ff);
               wr_data = rd_data;
               cur_in[AW'(j_ff)] = cur_ff[AW'(j_ff - 1'b1)];
               j_in    = j_ff - 1'b1;
               if (j_ff == CW'(1)) begin
                  wr_en = 1'b1;
               end
               state_in = S_SRDJ;
               if (j_ff - 1'b1 == '0) begin
                  state_in = S_SCMP;
               end
            end
            if (!(rd_data.expiry < key_ff.expiry) || j_ff == '0) begin
               wr_en   = 1'b1;
               wr_addr = AW'(j_ff);
               wr_data = key_ff;
               cur_in[AW'(j_ff)] = keyc_ff;
               i_in    = i_ff + 1'b1;
               rd_addr = AW'(i_ff + 1'b1);
               state_in = S_SRDI;
            end else if (j_ff != CW'(1)) begin
               rd_addr  = AW'(j_ff - 2'd2);
               state_in = S_SCMP;
            end else begin
               j_in     = '0;
               state_in = S_SCMP;
            end
         end
         S_TRD: begin
            if (count_ff == '0) begin
               state_in = S_MARK;
               i_in     = '0;
            end else begin
               rd_addr  = AW'(count_ff - 1'b1);
               state_in = S_TCHK;
            end
         end
         S_TCHK: begin
            if (count_ff > KEPT_C || rd_data.expiry <= now_ff) begin
               if (cur_ff[AW'(count_ff - 1'b1)]) chg_in = 1'b1;
               cur_in[AW'(count_ff - 1'b1)] = 1'b0;
               count_in = count_ff - 1'b1;
               state_in = S_TRD;
            end else begin
               i_in     = '0;
               k_in     = KW'(cur_cnt);
               state_in = S_MARK;
            end
         end
         S_MARK: begin
            if (i_ff >= count_ff || k_ff >= MAXC_C) begin
               ov_in = 1'b1; ost_in = ovf_ff ? ST_OVERFLOW : ST_OK; och_in = chg_ff;
               osv_in = 1'b0; olast_in = 1'b1; ohi_in = '0; olo_in = '0;
               rej_in = 1'b0; ovf_in = 1'b0;
               state_in = S_IDLE;
            end else begin
               if (!cur_ff[AW'(i_ff)]) begin
                  cur_in[AW'(i_ff)] = 1'b1;
                  k_in   = k_ff + 1'b1;
                  chg_in = 1'b1;
               end
               i_in = i_ff + 1'b1;
            end
         end
         S_RRD: begin
            if (!ov_ff || rsp_ready) begin
               if (i_ff >= count_ff || k_ff >= MAXC_C) begin
                  if (k_ff == '0) begin
                     ov_in = 1'b1; ost_in = ST_OK; och_in = 1'b0; osv_in = 1'b0;
                     olast_in = 1'b1; ohi_in = '0; olo_in = '0;
                  end
                  state_in = S_IDLE;
               end else begin
                  state_in = S_RCHK;
               end
            end
         end
         S_RCHK: begin
            if (cur_ff[AW'(i_ff)]) begin
               ov_in = 1'b1; ost_in = ST_OK; och_in = 1'b0; osv_in = 1'b1;
               ohi_in = rd_data.addr_hi; olo_in = rd_data.addr_lo;
               k_in = k_ff + 1'b1;
               olast_in = (k_ff + 1'b1 == MAXC_C) || (cur_cnt == (KW+1)'(k_ff + 1'b1));
            end
            i_in     = i_ff + 1'b1;
            rd_addr  = AW'(i_ff + 1'b1);
            state_in = S_RRD;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         min_life_ff <= '0;
         count_ff    <= '0;
         rej_ff      <= 1'b0;
         ovf_ff      <= 1'b0;
         cur_ff      <= '0;
         ov_ff       <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) min_life_ff <= csr_wr_data;
         count_ff <= count_in;
         rej_ff   <= rej_in;
         ovf_ff   <= ovf_in;
         cur_ff   <= cur_in;
         ov_ff    <= ov_in;
      end
      cmd_ff   <= cmd_in;
      ahi_ff   <= ahi_in;
      alo_ff   <= alo_in;
      now_ff   <= now_in;
      exp_ff   <= exp_in;
      last_ff  <= last_in;
      i_ff     <= i_in;
      j_ff     <= j_in;
      k_ff     <= k_in;
      chg_ff   <= chg_in;
      key_ff   <= key_in;
      keyc_ff  <= keyc_in;
      ost_ff   <= ost_in;
      och_ff   <= och_in;
      osv_ff   <= osv_in;
      olast_ff <= olast_in;
      ohi_ff   <= ohi_in;
      olo_ff   <= olo_in;
   end

   assign rsp_valid        = ov_ff;
   assign rsp_status       = ost_ff;
   assign rsp_changed      = och_ff;
   assign rsp_server_valid = osv_ff;
   assign rsp_server_hi    = ohi_ff;
   assign rsp_server_lo    = olo_ff;
   assign rsp_last_result  = olast_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_C) else $error("entry count past depth");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req_ready) else $error("ready while busy");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid) else $error("word dropped");

endmodule

FILE: tb/sv/dns_server_expiry_table_unit_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// dns_server_expiry_table_unit_tb
// Self-checking testbench for the DNS server expiry table. A behavioral
// predictor tracks the table, batch flags and lifetime floor, and queues the
// words each request should produce. Directed requests cover the edge cases;
// random batches then run under three sender/receiver idle profiles, with a
// long receiver hold-off and a full drain in between.
// ============================================================================
module dns_server_expiry_table_unit_tb;
   import dnsexp_pkg::*;

   localparam int  DEPTH      = 16;
   localparam int  KEPT       = 12;
   localparam int  CURRENT    = 3;
   localparam int  CYCLE_CAP  = 1000000;
   localparam int  SETTLE     = 120;

   typedef struct packed {
      logic [1:0]  status;
      logic        changed;
      logic        server_valid;
      logic [63:0] server_hi;
      logic [63:0] server_lo;
      logic        last_result;
   } rsp_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [31:0] csr_wr_data = '0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_command = '0;
   logic [63:0] req_address_hi = '0;
   logic [63:0] req_address_lo = '0;
   logic [31:0] req_lifetime_s = '0;
   logic [63:0] req_now_ms = '0;
   logic        req_last_in_batch = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_status;
   logic        rsp_changed;
   logic        rsp_server_valid;
   logic [63:0] rsp_server_hi;
   logic [63:0] rsp_server_lo;
   logic        rsp_last_result;

   dns_server_expiry_table_unit dut (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_command(req_command), .req_address_hi(req_address_hi),
      .req_address_lo(req_address_lo), .req_lifetime_s(req_lifetime_s),
      .req_now_ms(req_now_ms), .req_last_in_batch(req_last_in_batch),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_status(rsp_status), .rsp_changed(rsp_changed),
      .rsp_server_valid(rsp_server_valid), .rsp_server_hi(rsp_server_hi),
      .rsp_server_lo(rsp_server_lo), .rsp_last_result(rsp_last_result)
   );

   always #4 clock = ~clock;

   // table model
   entry_type   tbl [DEPTH];
   logic        tbl_cur [DEPTH];
   int          tbl_count;
   logic        flag_rejected;
   logic        flag_overflow;
   logic [31:0] floor_s;

   rsp_word_type pending_words [$];
   int          errors;
   int          cycle_count;
   int          send_idle_pct;
   int          recv_idle_pct;
   int          hold_cycles;
   logic [63:0] now_t;
   logic [63:0] pool_hi [8];
   logic [63:0] pool_lo [8];

   task automatic report(input string what);
      errors++;
      if (errors <= 100) $display("mismatch @%0t: %s", $realtime, what);
   endtask

   function automatic void push_word(input logic [1:0] st, input logic ch, input logic sv,
                                     input logic [63:0] hi, input logic [63:0] lo,
                                     input logic lst);
      rsp_word_type w;
      w.status = st; w.changed = ch; w.server_valid = sv;
      w.server_hi = hi; w.server_lo = lo; w.last_result = lst;
      pending_words.insert(pending_words.size(), w);
   endfunction

   function automatic logic close_batch(input logic [63:0] now);
      entry_type e;
      logic c, ch;
      int j, n;
      ch = 1'b0;
      for (int i = 1; i < tbl_count; i++) begin
         e = tbl[i]; c = tbl_cur[i]; j = i;
         while (j > 0 && tbl[j-1].expiry < e.expiry) begin
            tbl[j] = tbl[j-1]; tbl_cur[j] = tbl_cur[j-1]; j--;
         end
         tbl[j] = e; tbl_cur[j] = c;
      end
      while (tbl_count > 0 && (tbl_count - 1 >= KEPT || tbl[tbl_count-1].expiry <= now)) begin
         if (tbl_cur[tbl_count-1]) ch = 1'b1;
         tbl_cur[tbl_count-1] = 1'b0;
         tbl_count--;
      end
      n = 0;
      for (int i = 0; i < tbl_count; i++) if (tbl_cur[i]) n++;
      for (int i = 0; i < tbl_count && n < CURRENT; i++)
         if (!tbl_cur[i]) begin
            tbl_cur[i] = 1'b1; n++; ch = 1'b1;
         end
      return ch;
   endfunction

   function automatic void predict_table(input logic [1:0] cmd, input logic [63:0] hi,
                                         input logic [63:0] lo, input logic [31:0] life,
                                         input logic [63:0] now, input logic lst);
      logic had, found, ch;
      logic [63:0] exp_ms;
      int k;
      if (cmd == CMD_CLEAR) begin
         had = 1'b0;
         for (int i = 0; i < DEPTH; i++) begin
            if (i < tbl_count && tbl_cur[i]) had = 1'b1;
            tbl_cur[i] = 1'b0;
         end
         tbl_count = 0; flag_rejected = 0; flag_overflow = 0;
         push_word(ST_OK, had, 0, '0, '0, 1);
      end else if (cmd == CMD_ADD) begin
         if (life != 0 && life < floor_s) begin
            flag_rejected = 1'b1;
         end else begin
            exp_ms = now + 64'(life) * 64'(MS_PER_S);
            found = 1'b0;
            for (int i = 0; i < tbl_count && !found; i++)
               if (tbl[i].addr_hi == hi && tbl[i].addr_lo == lo) begin
                  tbl[i].expiry = exp_ms; found = 1'b1;
               end
            if (!found && exp_ms > now) begin
               if (tbl_count < DEPTH) begin
                  tbl[tbl_count] = '{addr_hi: hi, addr_lo: lo, expiry: exp_ms};
                  tbl_cur[tbl_count] = 1'b0;
                  tbl_count++;
               end else begin
                  flag_overflow = 1'b1;
               end
            end
         end
         if (lst) begin
            if (flag_rejected) begin
               push_word(ST_REJECTED, 0, 0, '0, '0, 1);
            end else begin
               ch = close_batch(now);
               push_word(flag_overflow ? ST_OVERFLOW : ST_OK, ch, 0, '0, '0, 1);
            end
            flag_rejected = 0; flag_overflow = 0;
         end
      end else if (cmd == CMD_READ) begin
         k = 0;
         for (int i = 0; i < tbl_count && k < CURRENT; i++)
            if (tbl_cur[i]) begin
               push_word(ST_OK, 0, 1, tbl[i].addr_hi, tbl[i].addr_lo, 0);
               k++;
            end
         if (k == 0) push_word(ST_OK, 0, 0, '0, '0, 1);
         else pending_words[$].last_result = 1'b1;
      end else begin
         push_word(ST_OK, 0, 0, '0, '0, 1);
      end
   endfunction

   task automatic send_word(input logic [1:0] cmd, input logic [63:0] hi,
                            input logic [63:0] lo, input logic [31:0] life,
                            input logic [63:0] now, input logic lst);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd; req_address_hi <= hi; req_address_lo <= lo;
      req_lifetime_s <= life; req_now_ms <= now; req_last_in_batch <= lst;
      do @(posedge clock); while (!req_ready);
      predict_table(cmd, hi, lo, life, now, lst);
   endtask

   task automatic drain;
      @(posedge clock);
      req_valid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_floor(input logic [31:0] val);
      drain();
      csr_wr_en <= 1'b1; csr_wr_data <= val;
      @(posedge clock);
      floor_s = val;
      csr_wr_en <= 1'b0;
   endtask

   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         rsp_ready <= 1'b0;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_words.size() == 0) begin
            report("response word with nothing pending");
         end else begin
            want = pending_words.pop_front();
            if (rsp_status !== want.status)
               report($sformatf("status %0d, want %0d", rsp_status, want.status));
            if (rsp_changed !== want.changed)
               report($sformatf("changed %0b, want %0b", rsp_changed, want.changed));
            if (rsp_server_valid !== want.server_valid)
               report($sformatf("server_valid %0b, want %0b", rsp_server_valid,
                                want.server_valid));
            if (rsp_server_hi !== want.server_hi)
               report($sformatf("server_hi %h, want %h", rsp_server_hi, want.server_hi));
            if (rsp_server_lo !== want.server_lo)
               report($sformatf("server_lo %h, want %h", rsp_server_lo, want.server_lo));
            if (rsp_last_result !== want.last_result)
               report($sformatf("last_result %0b, want %0b", rsp_last_result,
                                want.last_result));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_CAP) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   task automatic test_directed;
      logic [63:0] h;
      send_word(2'd3, '1, '1, '1, '1, 1);
      send_word(CMD_READ, '0, '0, '0, '0, 0);
      send_word(CMD_CLEAR, '0, '0, '0, '0, 0);
      send_word(CMD_ADD, '0, '0, 32'd10, now_t, 0);
      send_word(CMD_ADD, '1, '1, 32'd10, now_t, 0);
      send_word(CMD_ADD, pool_hi[0], pool_lo[0], 32'd10, now_t, 1);
      send_word(CMD_READ, '0, '0, '0, '0, 0);
      // refresh with lifetime zero expires a known entry
      send_word(CMD_ADD, '1, '1, 32'd0, now_t, 1);
      send_word(CMD_ADD, pool_hi[1], pool_lo[1], 32'd0, now_t, 1);
      // expiry wraps past 2^64
      send_word(CMD_ADD, pool_hi[2], pool_lo[2], 32'd1, 64'hFFFF_FFFF_FFFF_FE0C, 1);
      send_word(CMD_ADD, pool_hi[3], pool_lo[3], '1, now_t, 1);
      send_word(CMD_READ, '0, '0, '0, '0, 0);
      for (int i = 0; i < 17; i++) begin
         h = rand64();
         send_word(CMD_ADD, h, rand64(), 32'd100 + i, now_t, i == 16);
      end
      send_word(CMD_READ, '0, '0, '0, '0, 0);
      write_floor(32'd100);
      send_word(CMD_ADD, pool_hi[4], pool_lo[4], 32'd200, now_t, 0);
      send_word(CMD_ADD, pool_hi[5], pool_lo[5], 32'd50, now_t, 1);
      write_floor('1);
      send_word(CMD_ADD, pool_hi[6], pool_lo[6], '1, now_t, 0);
      send_word(CMD_ADD, pool_hi[7], pool_lo[7], 32'd5, now_t, 1);
      send_word(CMD_READ, '0, '0, '0, '0, 0);
      send_word(CMD_CLEAR, '1, '1, '1, '1, 1);
      send_word(CMD_READ, '0, '0, '0, '0, 0);
   endtask

   task automatic test_random(input int n_items, input int s_pct, input int r_pct);
      int sent, len, pick;
      logic [31:0] life;
      logic [63:0] now, hi, lo;
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      sent = 0;
      while (sent < n_items) begin
         pick = $urandom_range(99);
         if (pick < 70) begin
            now_t = now_t + $urandom_range(6000);
            len = $urandom_range(6, 1);
            life = ($urandom_range(9) == 0) ? $urandom() : $urandom_range(20);
            now = ($urandom_range(19) == 0) ? rand64() : now_t;
            for (int i = 0; i < len; i++) begin
               if ($urandom_range(1)) begin
                  pick = $urandom_range(7);
                  hi = pool_hi[pick]; lo = pool_lo[pick];
               end else begin
                  hi = rand64(); lo = rand64();
               end
               send_word(CMD_ADD, hi, lo, life, now, i == len - 1);
            end
            sent += len;
         end else if (pick < 85) begin
            send_word(CMD_READ, rand64(), rand64(), $urandom(), rand64(),
                      1'($urandom_range(1)));
            sent++;
         end else if (pick < 90) begin
            send_word(CMD_CLEAR, rand64(), rand64(), $urandom(), rand64(),
                      1'($urandom_range(1)));
            sent++;
         end else if (pick < 94) begin
            send_word(2'd3, rand64(), rand64(), $urandom(), rand64(), 1'($urandom_range(1)));
            sent++;
         end else begin
            // broken batch: item times and lifetimes disagree
            send_word(CMD_ADD, rand64(), rand64(), $urandom_range(30), rand64(),
                      1'($urandom_range(1)));
            send_word(CMD_ADD, rand64(), rand64(), $urandom(), now_t, 1);
            sent += 2;
         end
      end
   endtask

   task automatic test_pressure;
      send_idle_pct = 0;
      hold_cycles = 400;
      for (int i = 0; i < 8; i++) send_word(CMD_READ, '0, '0, '0, '0, 0);
      send_word(CMD_ADD, pool_hi[0], pool_lo[0], 32'd30, now_t, 1);
      for (int i = 0; i < 4; i++) send_word(CMD_READ, '0, '0, '0, '0, 0);
      drain();
   endtask

   initial begin
      errors = 0; cycle_count = 0; hold_cycles = 0;
      send_idle_pct = 10; recv_idle_pct = 50;
      tbl_count = 0; flag_rejected = 0; flag_overflow = 0; floor_s = '0;
      for (int i = 0; i < DEPTH; i++) tbl_cur[i] = 1'b0;
      now_t = 64'd1_000_000;
      for (int i = 0; i < 8; i++) begin
         pool_hi[i] = rand64(); pool_lo[i] = rand64();
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      write_floor(32'd0);
      test_random(130, 10, 50);
      test_pressure();
      write_floor(32'd4);
      test_random(130, 50, 10);
      write_floor($urandom_range(3));
      test_random(140, 0, 0);
      drain();
      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
